[hw/rtl/http_chunked_body_decoder_assert.svh]
// Assertion shorthands shared by the decoder modules.
// Each module that uses them has i_clk and i_rst_n in scope.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define CHD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define CHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

[hw/rtl/chd_pkg.sv]
`timescale 1ns / 1ps
package chd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [2:0] K_DATA = 3'd0;
    localparam logic [2:0] K_ZERO = 3'd1;
    localparam logic [2:0] K_BAD  = 3'd2;
    localparam logic [2:0] K_DROP = 3'd3;
    localparam logic [2:0] K_END  = 3'd4;

    // One body byte with its class, as the front hands it on.
    typedef struct packed {
        logic [7:0] data;
        logic       body_end;
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_item;

endpackage

[hw/rtl/chd_front.sv]
`timescale 1ns / 1ps
module chd_front (
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_body_byte,
    input  logic          i_body_end,
    input  logic          i_q_full,
    output logic          o_q_push,
    output chd_pkg::t_item o_q_item
);

    logic w_digit;
    logic w_alpha;

    always_comb begin
        w_digit = i_body_byte inside {[8'h30:8'h39]};
        w_alpha = i_body_byte inside {[8'h41:8'h46], [8'h61:8'h66]};
        o_q_item.data     = i_body_byte;
        o_q_item.body_end = i_body_end;
        o_q_item.is_cr    = (i_body_byte == chd_pkg::CHAR_CR);
        o_q_item.is_lf    = (i_body_byte == chd_pkg::CHAR_LF);
        o_q_item.is_blank = (i_body_byte == chd_pkg::CHAR_SPACE)
                         || (i_body_byte == chd_pkg::CHAR_TAB);
        o_q_item.is_hex   = w_digit || w_alpha;
        // letters a..f and A..F share a low nibble of 1..6
        o_q_item.hex_val  = w_digit ? i_body_byte[3:0] : (i_body_byte[3:0] + 4'd9);
    end

    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full;

endmodule

[hw/rtl/chd_queue.sv]
`timescale 1ns / 1ps
module chd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chd_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output chd_pkg::t_item o_item,
    input  logic           i_pop
);

    localparam int Depth = chd_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    chd_pkg::t_item r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`include "http_chunked_body_decoder_assert.svh"
    `CHD_ASSERT_IMPL(a_empty_ptrs, r_count == '0, r_wr_ptr == r_rd_ptr)

endmodule

[hw/rtl/chd_back.sv]
`timescale 1ns / 1ps
module chd_back #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  chd_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_payload_byte,
    output logic [2:0]     o_result_kind,
    output logic           o_last_of_run
);

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_DIGITS = 6'b000010,
        PH_REST   = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_SKIP   = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic                 r_cr, n_cr;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_digit, n_digit;
    logic [SIZE_BITS-1:0] r_left, n_left;
    logic [1:0]           r_skip, n_skip;
    logic                 r_part, n_part;

    logic                 r_out_v;
    logic [7:0]           r_out_byte;
    logic [2:0]           r_out_kind;
    logic                 r_out_last;
    logic                 r_hold_v;
    logic [2:0]           r_hold_kind;

    logic                 w_out_free;
    logic                 w_p_v;
    logic [2:0]           w_p_kind;
    logic [7:0]           w_p_byte;
    logic [2:0]           w_e_kind;

    assign w_out_free = !r_out_v || !i_stall;
    assign o_q_pop    = i_q_valid && !r_hold_v && w_out_free;

    always_comb begin
        n_phase  = r_phase;
        n_cr     = r_cr;
        n_size   = r_size;
        n_digit  = r_digit;
        n_left   = r_left;
        n_skip   = r_skip;
        n_part   = r_part;
        w_p_v    = 1'b0;
        w_p_kind = chd_pkg::K_DATA;
        w_p_byte = 8'd0;
        w_e_kind = chd_pkg::K_END;
        case (r_phase)
            PH_START, PH_DIGITS, PH_REST: begin
                if (r_cr && i_q_item.is_lf) begin
                    n_cr = 1'b0;
                    if (!r_digit) begin
                        w_p_v    = 1'b1;
                        w_p_kind = chd_pkg::K_BAD;
                        n_phase  = PH_DONE;
                    end else if (r_size == '0) begin
                        w_p_v    = 1'b1;
                        w_p_kind = chd_pkg::K_ZERO;
                        n_phase  = PH_DONE;
                    end else begin
                        n_left  = r_size;
                        n_part  = 1'b0;
                        n_phase = PH_DATA;
                    end
                end else if (i_q_item.is_cr) begin
                    n_cr    = 1'b1;
                    n_phase = PH_REST;
                end else begin
                    n_cr = 1'b0;
                    if (r_phase == PH_START && i_q_item.is_blank) begin
                        n_phase = r_phase;
                    end else if (r_phase != PH_REST && i_q_item.is_hex) begin
                        // another digit would overflow the size field
                        if (r_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                            w_p_v    = 1'b1;
                            w_p_kind = chd_pkg::K_BAD;
                            n_phase  = PH_DONE;
                        end else begin
                            n_size  = {r_size[SIZE_BITS-5:0], i_q_item.hex_val};
                            n_digit = 1'b1;
                            n_phase = PH_DIGITS;
                        end
                    end else begin
                        n_phase = PH_REST;
                    end
                end
            end
            PH_DATA: begin
                if (r_left == '0) begin
                    n_phase = PH_DONE;
                end else begin
                    w_p_v    = 1'b1;
                    w_p_kind = chd_pkg::K_DATA;
                    w_p_byte = i_q_item.data;
                    n_left   = r_left - 1'b1;
                    n_part   = 1'b1;
                    if (r_left == SIZE_BITS'(1)) begin
                        n_skip  = 2'd2;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (r_skip <= 2'd1) begin
                    n_phase = PH_START;
                    n_cr    = 1'b0;
                    n_size  = '0;
                    n_digit = 1'b0;
                    n_left  = '0;
                    n_skip  = 2'd0;
                    n_part  = 1'b0;
                end else begin
                    n_skip = r_skip - 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (i_q_item.body_end) begin
            // a chunk cut short after some payload went out must be dropped
            w_e_kind = (n_phase == PH_DATA && n_part) ? chd_pkg::K_DROP : chd_pkg::K_END;
            n_phase  = PH_START;
            n_cr     = 1'b0;
            n_size   = '0;
            n_digit  = 1'b0;
            n_left   = '0;
            n_skip   = 2'd0;
            n_part   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_cr    <= 1'b0;
            r_size  <= '0;
            r_digit <= 1'b0;
            r_left  <= '0;
            r_skip  <= 2'd0;
            r_part  <= 1'b0;
        end else if (o_q_pop) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_size  <= n_size;
            r_digit <= n_digit;
            r_left  <= n_left;
            r_skip  <= n_skip;
            r_part  <= n_part;
        end
    end

    // Output register with one spare slot for the end-of-body result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_hold_v) begin
                r_out_v  <= 1'b1;
                r_hold_v <= 1'b0;
            end else if (o_q_pop && (w_p_v || i_q_item.body_end)) begin
                r_out_v  <= 1'b1;
                r_hold_v <= w_p_v && i_q_item.body_end;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_hold_v) begin
                r_out_byte <= 8'd0;
                r_out_kind <= r_hold_kind;
                r_out_last <= 1'b1;
            end else if (w_p_v) begin
                r_out_byte  <= w_p_byte;
                r_out_kind  <= w_p_kind;
                r_out_last  <= !i_q_item.body_end;
                r_hold_kind <= w_e_kind;
            end else begin
                r_out_byte <= 8'd0;
                r_out_kind <= w_e_kind;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_payload_byte = r_out_byte;
    assign o_result_kind  = r_out_kind;
    assign o_last_of_run  = r_out_last;

`include "http_chunked_body_decoder_assert.svh"
    `CHD_ASSERT_IMPL(a_hold_behind_first, r_hold_v, r_out_v && !r_out_last)
    `CHD_ASSERT_IMPL(a_marker_no_byte, r_out_v && r_out_kind != chd_pkg::K_DATA, r_out_byte == 8'd0)
    `CHD_ASSERT_NEXT(a_hold_moves_out, r_hold_v && !i_stall, r_out_v && r_out_last && !r_hold_v)

endmodule

[hw/rtl/http_chunked_body_decoder.sv]
`timescale 1ns / 1ps
// A byte transferred in is written to the queue; the back end pops it and registers
// its result. Throughput: one byte per cycle while the queue is not full and the
// output is not stalled; a byte that gives two results (a marker plus the body-end
// result) parks the second in a spare slot, and no byte is popped until it moves out.
// A two-entry queue decouples byte intake from result delivery. Reset (synchronous,
// active low) empties the queue and output and resets framing to a size line's start.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_body_byte,
    input  logic       i_body_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_result_kind,
    output logic       o_last_of_run
);

    logic           w_push;
    logic           w_full;
    logic           w_q_valid;
    logic           w_pop;
    chd_pkg::t_item w_in_item;
    chd_pkg::t_item w_q_item;

    chd_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_body_byte (i_body_byte),
        .i_body_end  (i_body_end),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_q_item    (w_in_item)
    );

    chd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    chd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_result_kind  (o_result_kind),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
